// ----- rtl/teq_pkg.sv -----
// shared types and constants of the timestamp ordered event queue
// used by teq_ram, timestamp_ordered_event_queue, teq_checker and the testbench; no dependencies
package teq_pkg;

  // queue depth, a power of two so that ring addresses wrap by truncation
  localparam int unsigned Depth    = 16;
  localparam int unsigned IdxW     = $clog2(Depth);
  localparam int unsigned CntW     = IdxW + 1;
  localparam int unsigned TimeW    = 64;
  localparam int unsigned TagW     = 16;
  localparam int unsigned StatusW  = 3;
  localparam int unsigned InDataW  = 80;
  localparam int unsigned OutDataW = 88;

  typedef enum logic {
    FUNC_ADD     = 1'b0,
    FUNC_PROCEED = 1'b1
  } func_e;

  typedef enum logic [StatusW-1:0] {
    ST_ADDED = 3'd0,
    ST_FIRED = 3'd1,
    ST_PAST  = 3'd2,
    ST_FULL  = 3'd3,
    ST_EMPTY = 3'd4
  } status_e;

  typedef struct packed {
    logic [TimeW-1:0] ev_time;
    logic [TagW-1:0]  ev_tag;
  } entry_t;

endpackage

// ----- rtl/teq_ram.sv -----
// event storage ring: one write port, one read port with registered data
// depends on teq_pkg
module teq_ram (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [teq_pkg::IdxW-1:0] waddr_i,
  input  teq_pkg::entry_t          wdata_i,
  input  logic [teq_pkg::IdxW-1:0] raddr_i,
  output teq_pkg::entry_t          rdata_o
);

  teq_pkg::entry_t mem_q [teq_pkg::Depth];
  teq_pkg::entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/timestamp_ordered_event_queue.sv -----
// timestamp ordered event queue: sequencer around an event ring; uses teq_pkg and teq_ram
// add: the item is latched and classified, later entries move up from the tail, then it is written
// past/full/empty answers come from the classify step; proceed: the head entry sets the new time,
// then one fired item per cycle while the output is free; ready again once the last result is
// registered; result stalls hold the sequencer; one 64-bit compare unit and one read port pace it
// reset: asynchronous active low, queue emptied, current time zero; ring contents undefined
module timestamp_ordered_event_queue (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // input items
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  input  logic [teq_pkg::InDataW-1:0]       s_axis_tdata_i,  // ev_time[63:0], ev_tag[79:64]
  input  logic                              s_axis_tuser_i,  // func
  // result items
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  output logic [teq_pkg::OutDataW-1:0]      m_axis_tdata_o,  // fired_tag[15:0], time_now[79:16],
                                                             // queue_empty[80], zero[87:81]
  output logic [teq_pkg::StatusW-1:0]       m_axis_tuser_o,  // status
  output logic                              m_axis_tlast_o   // is_last
);

  // one-hot sequencer states
  typedef enum logic [6:0] {
    S_IDLE      = 7'b0000001,
    S_DECIDE    = 7'b0000010,  // classify the latched item
    S_ADD_CMP   = 7'b0000100,  // walk back from the tail, shifting later entries up
    S_ADD_WR0   = 7'b0001000,  // new event goes to the head slot
    S_ADD_DONE  = 7'b0010000,  // post the add status
    S_PRO_FIRST = 7'b0100000,  // head entry arrives, it sets the new time
    S_PRO_LOOK  = 7'b1000000   // fire one event per cycle while the output is free, look one entry ahead
  } state_e;

  localparam int unsigned IdxW = teq_pkg::IdxW;
  localparam int unsigned CntW = teq_pkg::CntW;

  state_e state_q, state_d;

  // queue bookkeeping
  logic [IdxW-1:0]          head_q, head_d;
  logic [CntW-1:0]          count_q, count_d;
  logic [IdxW-1:0]          idx_q, idx_d;
  logic [teq_pkg::TimeW-1:0] now_q, now_d;
  logic [teq_pkg::TimeW-1:0] front_q, front_d;
  logic [teq_pkg::TagW-1:0]  cur_tag_q, cur_tag_d;

  // latched input item
  logic                      in_func_q;
  logic [teq_pkg::TimeW-1:0] in_time_q;
  logic [teq_pkg::TagW-1:0]  in_tag_q;

  // ring port signals
  logic            ram_we;
  logic [IdxW-1:0] ram_waddr;
  logic [IdxW-1:0] ram_raddr;
  teq_pkg::entry_t ram_wdata;
  teq_pkg::entry_t ram_rdata;

  // result register
  logic                      out_valid_q;
  teq_pkg::status_e          out_status_q;
  logic [teq_pkg::TagW-1:0]  out_tag_q;
  logic [teq_pkg::TimeW-1:0] out_time_q;
  logic                      out_last_q;
  logic                      out_empty_q;

  // result being produced this cycle
  logic                      emit;
  teq_pkg::status_e          e_status;
  logic [teq_pkg::TagW-1:0]  e_tag;
  logic [teq_pkg::TimeW-1:0] e_time;
  logic                      e_last;
  logic                      e_empty;

  logic in_accept;
  logic out_free;

  // shared compare unit: past check of the new time against the current time,
  // insert scan against the new time, proceed against the front time
  logic [teq_pkg::TimeW-1:0] cmp_a;
  logic [teq_pkg::TimeW-1:0] cmp_b;
  logic                      cmp_gt;
  logic                      cmp_eq;
  logic                      fire_last;

  assign in_accept = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free  = !out_valid_q || m_axis_tready_i;

  assign cmp_a  = (state_q == S_DECIDE) ? now_q : ram_rdata.ev_time;
  assign cmp_b  = (state_q == S_PRO_LOOK) ? front_q : in_time_q;
  assign cmp_gt = cmp_a > cmp_b;
  assign cmp_eq = cmp_a == cmp_b;

  // the fired entry is the last of its time if nothing follows or the next time differs
  assign fire_last = (count_q == CntW'(1)) || !cmp_eq;

  teq_ram u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d   = state_q;
    head_d    = head_q;
    count_d   = count_q;
    idx_d     = idx_q;
    now_d     = now_q;
    front_d   = front_q;
    cur_tag_d = cur_tag_q;

    ram_we    = 1'b0;
    ram_waddr = head_q;
    ram_wdata = '{ev_time: in_time_q, ev_tag: in_tag_q};
    ram_raddr = head_q;

    emit     = 1'b0;
    e_status = teq_pkg::ST_ADDED;
    e_tag    = '0;
    e_time   = now_q;
    e_last   = 1'b1;
    e_empty  = (count_q == '0);

    unique case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          state_d = S_DECIDE;
        end
      end

      S_DECIDE: begin
        if (in_func_q == teq_pkg::FUNC_ADD) begin
          if (cmp_gt) begin
            // new time below the current time; time in past wins over queue full
            if (out_free) begin
              emit     = 1'b1;
              e_status = teq_pkg::ST_PAST;
              state_d  = S_IDLE;
            end
          end else if (count_q == CntW'(teq_pkg::Depth)) begin
            if (out_free) begin
              emit     = 1'b1;
              e_status = teq_pkg::ST_FULL;
              state_d  = S_IDLE;
            end
          end else if (count_q == '0) begin
            ram_we    = 1'b1;
            ram_waddr = head_q;
            state_d   = S_ADD_DONE;
          end else begin
            idx_d     = IdxW'(count_q - CntW'(1));
            ram_raddr = head_q + IdxW'(count_q - CntW'(1));
            state_d   = S_ADD_CMP;
          end
        end else begin
          if (count_q == '0) begin
            if (out_free) begin
              emit     = 1'b1;
              e_status = teq_pkg::ST_EMPTY;
              state_d  = S_IDLE;
            end
          end else begin
            ram_raddr = head_q;
            state_d   = S_PRO_FIRST;
          end
        end
      end

      S_ADD_CMP: begin
        ram_waddr = head_q + idx_q + IdxW'(1);
        ram_we    = 1'b1;
        if (cmp_gt) begin
          // later entry moves up one slot
          ram_wdata = ram_rdata;
          if (idx_q == '0) begin
            state_d = S_ADD_WR0;
          end else begin
            idx_d     = idx_q - IdxW'(1);
            ram_raddr = head_q + idx_q - IdxW'(1);
          end
        end else begin
          state_d = S_ADD_DONE;
        end
      end

      S_ADD_WR0: begin
        ram_we    = 1'b1;
        ram_waddr = head_q;
        state_d   = S_ADD_DONE;
      end

      S_ADD_DONE: begin
        if (out_free) begin
          emit     = 1'b1;
          e_status = teq_pkg::ST_ADDED;
          e_empty  = 1'b0;
          count_d  = count_q + CntW'(1);
          state_d  = S_IDLE;
        end
      end

      S_PRO_FIRST: begin
        front_d   = ram_rdata.ev_time;
        now_d     = ram_rdata.ev_time;
        cur_tag_d = ram_rdata.ev_tag;
        ram_raddr = head_q + IdxW'(1);
        state_d   = S_PRO_LOOK;
      end

      S_PRO_LOOK: begin
        // read data always holds the entry after the one being fired
        ram_raddr = head_q + IdxW'(1);
        if (out_free) begin
          emit     = 1'b1;
          e_status = teq_pkg::ST_FIRED;
          e_tag    = cur_tag_q;
          e_last   = fire_last;
          e_empty  = (count_q == CntW'(1));
          head_d   = head_q + IdxW'(1);
          count_d  = count_q - CntW'(1);
          if (fire_last) begin
            state_d = S_IDLE;
          end else begin
            cur_tag_d = ram_rdata.ev_tag;
            ram_raddr = head_q + IdxW'(2);
          end
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      count_q     <= '0;
      now_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      count_q <= count_d;
      now_q   <= now_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    idx_q     <= idx_d;
    front_q   <= front_d;
    cur_tag_q <= cur_tag_d;
    if (in_accept) begin
      in_func_q <= s_axis_tuser_i;
      in_time_q <= s_axis_tdata_i[teq_pkg::TimeW-1:0];
      in_tag_q  <= s_axis_tdata_i[teq_pkg::TimeW +: teq_pkg::TagW];
    end
    if (emit) begin
      out_status_q <= e_status;
      out_tag_q    <= e_tag;
      out_time_q   <= e_time;
      out_last_q   <= e_last;
      out_empty_q  <= e_empty;
    end
  end

  assign s_axis_tready_o = (state_q == S_IDLE);

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_status_q;
  assign m_axis_tlast_o  = out_last_q;
  assign m_axis_tdata_o  = {7'b0, out_empty_q, out_time_q, out_tag_q};

endmodule

// ----- rtl/teq_checker.sv -----
// port level checks of the timestamp ordered event queue, bound to the top level
// depends on teq_pkg and timestamp_ordered_event_queue
module teq_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         m_axis_tvalid_o,
  input logic                         m_axis_tready_i,
  input logic [teq_pkg::OutDataW-1:0] m_axis_tdata_o,
  input logic [teq_pkg::StatusW-1:0]  m_axis_tuser_o,
  input logic                         m_axis_tlast_o
);

  // stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("stalled result item changed");

  // only fired items carry a tag
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tuser_o != teq_pkg::ST_FIRED) |->
      m_axis_tdata_o[teq_pkg::TagW-1:0] == '0)
    else $error("tag on a non-fired item");

  // status answers are single items
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tuser_o != teq_pkg::ST_FIRED) |-> m_axis_tlast_o)
    else $error("status item without last");

  // empty answer reports an empty queue, added answer a non-empty one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tuser_o == teq_pkg::ST_EMPTY) |->
      m_axis_tdata_o[teq_pkg::TagW + teq_pkg::TimeW])
    else $error("empty answer with events pending");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tuser_o == teq_pkg::ST_ADDED) |->
      !m_axis_tdata_o[teq_pkg::TagW + teq_pkg::TimeW])
    else $error("queue empty after an add");

endmodule

bind timestamp_ordered_event_queue teq_checker u_teq_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);

// ----- tb/timestamp_ordered_event_queue_test.sv -----
// self-checking testbench for timestamp_ordered_event_queue: directed and random add and
// proceed items, results checked against a shadow time-ordered queue kept in the testbench
// depends on teq_pkg and the rtl of timestamp_ordered_event_queue
`timescale 1ns / 1ps

module timestamp_ordered_event_queue_test;

  localparam int unsigned IdlePct  = 27;
  localparam int unsigned HoldAt   = 120;   // items in before the long receiver hold
  localparam int unsigned HoldLen  = 250;   // cycles of that hold
  localparam int unsigned NoIdleLo = 300;   // items in where both sides stop idling
  localparam int unsigned NoIdleHi = 380;
  localparam int unsigned Settle   = 40;    // quiet cycles after the last result

  localparam logic [teq_pkg::TimeW-1:0] MaxTime = {teq_pkg::TimeW{1'b1}};

  typedef struct {
    teq_pkg::func_e            func;
    logic [teq_pkg::TimeW-1:0] ev_time;
    logic [teq_pkg::TagW-1:0]  ev_tag;
    bit                        drain_first;  // hold this item back until nothing is due
  } stim_t;

  typedef struct {
    teq_pkg::status_e          status;
    logic [teq_pkg::TagW-1:0]  tag;
    logic [teq_pkg::TimeW-1:0] now;
    logic                      last;
    logic                      empty;
  } answer_t;

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         s_valid = 1'b0;
  logic                         s_ready;
  logic [teq_pkg::InDataW-1:0]  s_data = '0;
  logic                         s_user = teq_pkg::FUNC_ADD;
  logic                         m_valid;
  logic                         m_ready = 1'b0;
  logic [teq_pkg::OutDataW-1:0] m_data;
  logic [teq_pkg::StatusW-1:0]  m_user;
  logic                         m_last;

  stim_t   pending_items[$];
  answer_t due_answers[$];

  // shadow of the block: events in time order, equal times in arrival order
  teq_pkg::entry_t           shadow_events[$];
  logic [teq_pkg::TimeW-1:0] shadow_now = '0;

  int unsigned items_in = 0;
  int unsigned errors = 0;
  int unsigned n_added = 0, n_fired = 0, n_past = 0, n_full = 0, n_empty = 0;

  timestamp_ordered_event_queue DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .m_axis_tuser_o  (m_user),
    .m_axis_tlast_o  (m_last)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  function automatic void due(teq_pkg::status_e st, logic [teq_pkg::TagW-1:0] tag, bit last,
                              bit empty);
    answer_t a;
    a.status = st;
    a.tag    = tag;
    a.now    = shadow_now;
    a.last   = last;
    a.empty  = empty;
    due_answers.push_back(a);
  endfunction

  // applies one accepted item to the shadow queue and files the answers it causes
  function automatic void shadow_event_queue(stim_t it);
    int unsigned               pos;
    int unsigned               n;
    int unsigned               cnt;
    teq_pkg::entry_t           e;
    logic [teq_pkg::TimeW-1:0] front;
    cnt = shadow_events.size();
    if (it.func == teq_pkg::FUNC_ADD) begin
      if (it.ev_time < shadow_now) begin
        due(teq_pkg::ST_PAST, '0, 1'b1, cnt == 0);
      end else if (cnt >= teq_pkg::Depth) begin
        due(teq_pkg::ST_FULL, '0, 1'b1, cnt == 0);
      end else begin
        pos = 0;
        while (pos < cnt && shadow_events[pos].ev_time <= it.ev_time) pos++;
        e.ev_time = it.ev_time;
        e.ev_tag  = it.ev_tag;
        shadow_events.insert(pos, e);
        due(teq_pkg::ST_ADDED, '0, 1'b1, 1'b0);
      end
    end else if (cnt == 0) begin
      due(teq_pkg::ST_EMPTY, '0, 1'b1, 1'b1);
    end else begin
      front      = shadow_events[0].ev_time;
      shadow_now = front;
      n = 0;
      while (n < cnt && shadow_events[n].ev_time == front) n++;
      for (int unsigned i = 0; i < n; i++) begin
        e = shadow_events[0];
        shadow_events.delete(0);
        due(teq_pkg::ST_FIRED, e.ev_tag, i + 1 == n, cnt - i - 1 == 0);
      end
    end
  endfunction

  function automatic void check_field(string what, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, what, want, got);
    end
  endfunction

  function automatic void push_add(logic [teq_pkg::TimeW-1:0] t, logic [teq_pkg::TagW-1:0] tag,
                                   bit drain);
    stim_t it;
    it.func        = teq_pkg::FUNC_ADD;
    it.ev_time     = t;
    it.ev_tag      = tag;
    it.drain_first = drain;
    pending_items.push_back(it);
  endfunction

  function automatic void push_proceed(bit drain);
    stim_t it;
    it.func        = teq_pkg::FUNC_PROCEED;
    it.ev_time     = {$urandom, $urandom};  // ignored by the block, toggled anyway
    it.ev_tag      = 16'($urandom_range(0, 65535));
    it.drain_first = drain;
    pending_items.push_back(it);
  endfunction

  // sender: keeps an item up until it is taken, idles only between items
  always @(posedge clk_i) begin : drive_p
    stim_t cur;
    bit    busy;
    bit    offer;
    bit    calm;
    if (rst_ni) begin
      busy = s_valid;
      if (s_valid && s_ready) begin
        shadow_event_queue(cur);
        items_in++;
        busy = 1'b0;
      end
      if (!busy) begin
        offer = 1'b0;
        calm  = items_in >= NoIdleLo && items_in < NoIdleHi;
        if (pending_items.size() != 0) begin
          if (pending_items[0].drain_first && due_answers.size() != 0) begin
            offer = 1'b0;
          end else if (calm || $urandom_range(0, 99) >= IdlePct) begin
            cur   = pending_items[0];
            pending_items.delete(0);
            offer = 1'b1;
          end
        end
        s_valid <= offer;
        if (offer) begin
          s_data <= {cur.ev_tag, cur.ev_time};
          s_user <= cur.func;
        end
      end
    end
  end

  // receiver ready, with one long hold counted here
  always @(posedge clk_i) begin : ready_p
    int unsigned hold_left;
    bit          hold_done;
    bit          calm;
    if (rst_ni) begin
      if (!hold_done && items_in >= HoldAt) begin
        hold_left = HoldLen;
        hold_done = 1'b1;
      end
      calm = items_in >= NoIdleLo && items_in < NoIdleHi;
      if (hold_left != 0) begin
        hold_left--;
        m_ready <= 1'b0;
      end else begin
        m_ready <= calm || $urandom_range(0, 99) >= IdlePct;
      end
    end
  end

  // result checker
  always @(posedge clk_i) begin : watch_p
    answer_t want;
    if (rst_ni && m_valid && m_ready) begin
      if (due_answers.size() == 0) begin
        errors++;
        $display("%0t: result with nothing expected, status %0d tag 0x%0h", $time, m_user,
                 m_data[15:0]);
      end else begin
        want = due_answers[0];
        due_answers.delete(0);
        check_field("status", 64'(want.status), 64'(m_user));
        check_field("fired_tag", 64'(want.tag), 64'(m_data[15:0]));
        check_field("time_now", want.now, m_data[79:16]);
        check_field("queue_empty", 64'(want.empty), 64'(m_data[80]));
        check_field("tdata pad", '0, 64'(m_data[87:81]));
        check_field("tlast", 64'(want.last), 64'(m_last));
        case (want.status)
          teq_pkg::ST_ADDED: n_added++;
          teq_pkg::ST_FIRED: n_fired++;
          teq_pkg::ST_PAST:  n_past++;
          teq_pkg::ST_FULL:  n_full++;
          teq_pkg::ST_EMPTY: n_empty++;
          default: ;
        endcase
      end
    end
  end

  initial begin : stimulus
    logic [teq_pkg::TimeW-1:0] base;
    int unsigned               mode_left;
    int unsigned               p_proceed;
    int unsigned               roll;
    bit                        drain;

    // directed: empty proceed, equal times, add at the current time, past, full
    push_proceed(0);
    push_add(64'd5, 16'h0000, 0);
    push_add(64'd5, 16'hFFFF, 0);
    push_add(64'd0, 16'h1234, 0);
    push_proceed(0);
    push_proceed(0);
    push_add(64'd4, 16'h00F0, 0);           // one tick behind the current time
    push_add(64'd5, 16'h00AA, 0);           // exactly the current time
    for (int i = 0; i < 15; i++)
      push_add(64'd6 + 64'(i % 5), 16'($urandom_range(0, 65535)), 0);
    push_add(64'd3, 16'h0BAD, 0);           // past while full, past wins
    push_add(64'd100, 16'h0C0C, 0);         // full
    push_proceed(0);

    // random: phases rich in adds (fill up, hit full) and rich in proceeds (drain)
    base      = 64'd16;
    mode_left = 0;
    p_proceed = 30;
    for (int k = 0; k < 410; k++) begin
      if (mode_left == 0) begin
        mode_left = $urandom_range(20, 50);
        p_proceed = $urandom_range(0, 1) ? 15 : 50;
      end
      mode_left--;
      drain = (k == 200);
      roll  = $urandom_range(0, 99);
      if (roll < p_proceed) begin
        push_proceed(drain);
      end else if (roll < p_proceed + 7) begin
        push_add({$urandom, $urandom} % (base + 64'd1), 16'($urandom_range(0, 65535)), drain);
      end else begin
        if ($urandom_range(0, 9) == 0 && base < 64'h4000_0000_0000_0000)
          base += 64'd8 + ({$urandom, $urandom} >> $urandom_range(6, 63));
        push_add(base + 64'($urandom_range(0, 7)), 16'($urandom_range(0, 65535)), drain);
      end
    end

    // tail: empty the queue, then the top of the time range
    push_proceed(1);
    for (int i = 0; i < 16; i++) push_proceed(0);
    push_add(MaxTime, 16'hFFFF, 0);
    push_add(MaxTime, 16'h0000, 0);
    push_add({1'b1, 31'($urandom_range(0, 32'h7FFF_FFFF)), $urandom},
             16'($urandom_range(0, 65535)), 0);
    push_proceed(0);
    push_proceed(0);
    push_add(MaxTime - 64'd1, 16'h5A5A, 0);
    push_add(MaxTime, 16'hA5A5, 0);
    push_proceed(0);
    push_proceed(0);

    while (pending_items.size() != 0 || s_valid || due_answers.size() != 0) @(posedge clk_i);
    repeat (Settle) @(posedge clk_i);

    $display("covered %0d items: %0d added, %0d fired, %0d past, %0d full, %0d empty",
             items_in, n_added, n_fired, n_past, n_full, n_empty);
    $display("including a long output hold, a drain pause and the top of the time range");
    if (errors == 0 && due_answers.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin : watchdog
    #3_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/teq_pkg.sv
rtl/teq_ram.sv
rtl/timestamp_ordered_event_queue.sv
rtl/teq_checker.sv
tb/timestamp_ordered_event_queue_test.sv
